// File: hdl/tccs_pkg.sv
package tccs_pkg;

  typedef logic [15:0] cell_t;
  typedef logic [7:0]  char_t;
  typedef logic [3:0]  color_t;

  // Input kind carried on the slave-side tuser
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd1;

  localparam char_t  NEWLINE_CODE  = 8'd10;
  localparam char_t  SPACE_CODE    = 8'd32;
  localparam color_t FG_RESET      = 4'd7;
  localparam color_t BG_RESET      = 4'd0;
  localparam cell_t  RESET_CELL    = 16'h0720;

  function automatic cell_t make_cell(input char_t ch, input color_t fg, input color_t bg);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

// File: hdl/text_console_cursor_scroll.sv
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// s_*       | in        | tuser: opcode; tdata: char_code, read_row, read_column
// m_*       | out       | tdata: cursor_column, cursor_row, read_cell, scrolled
// cfg_*     | in        | write-only: foreground_color (0), background_color (1)
//
// A put request that does not scroll writes its result straight to the output
// register when that is free. A read request passes through a delivery state, as
// the cell memory read is registered. A put or newline that scrolls first sweeps
// the new bottom row one cell per cycle through the single memory write port.
// After rst the block runs a clearing pass over all ROWS*COLUMNS cells (2000 at the
// default size) before it takes the first request; cfg writes are taken meanwhile.
// A stalled m_* side holds the finished result in the output register.
module text_console_cursor_scroll #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_column[19:13], zero
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                 // read_cell[27:12], scrolled[28], zero
  input  logic        cfg_we,
  input  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned DEPTH = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [RW-1:0] BOTTOM_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [6:0]    ROWS_7     = 7'(ROWS);
  localparam logic [8:0]    COLS_9     = 9'(COLUMNS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCROLL, ST_DELIVER} state_t;

  state_t                 state;
  logic [AW-1:0]          clr_addr;
  logic [CW-1:0]          clr_col;
  logic [RW-1:0]          top;
  logic [RW-1:0]          cur_row;
  logic [CW-1:0]          cur_col;
  tccs_pkg::color_t       fg;
  tccs_pkg::color_t       bg;
  logic                   pend_read_ok;
  logic                   pend_scrolled;

  // Request decode
  logic                   accept;
  logic                   is_read;
  logic                   is_newline;
  tccs_pkg::char_t        ch;
  logic [4:0]             rd_row_in;
  logic [6:0]             rd_col_in;
  logic                   rd_in_range;
  logic [RW+4:0]          rd_row_ext;
  logic [CW+6:0]          rd_col_ext;
  logic [RW-1:0]          rd_row;
  logic [CW-1:0]          rd_col;

  // Cursor advance
  logic                   wrap;
  logic                   scroll;
  logic [RW-1:0]          row_next;
  logic [CW-1:0]          col_next;
  logic [RW-1:0]          top_next;
  logic                   out_free;
  logic                   out_load;

  // Memory side
  logic [RW-1:0]          map_row;
  logic [CW-1:0]          map_col;
  logic [AW-1:0]          map_addr;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  tccs_pkg::cell_t        mem_wdata;
  tccs_pkg::cell_t        mem_rdata;

  // Output packing
  logic [CW+6:0]          out_col_ext;
  logic [RW+4:0]          out_row_ext;
  tccs_pkg::cell_t        out_cell;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign is_read    = (s_tuser == tccs_pkg::OP_READ);
  assign ch         = s_tdata[7:0];
  assign is_newline = (ch == tccs_pkg::NEWLINE_CODE);
  assign rd_row_in  = s_tdata[12:8];
  assign rd_col_in  = s_tdata[19:13];
  assign out_free   = !m_tvalid || m_tready;

  // Out-of-range reads return zero and touch nothing
  assign rd_in_range = ({2'b00, rd_row_in} < ROWS_7) && ({2'b00, rd_col_in} < COLS_9);
  assign rd_row_ext  = {{RW{1'b0}}, rd_row_in};
  assign rd_col_ext  = {{CW{1'b0}}, rd_col_in};
  assign rd_row      = rd_row_ext[RW-1:0];
  assign rd_col      = rd_col_ext[CW-1:0];

  // Advance the cursor: wrap on newline or past the last column, scroll off the bottom
  always_comb begin
    wrap     = is_newline || (cur_col == LAST_COL);
    scroll   = wrap && (cur_row == BOTTOM_ROW);
    col_next = wrap ? '0 : cur_col + 1'b1;
    row_next = (wrap && !scroll) ? cur_row + 1'b1 : cur_row;
    top_next = (top == BOTTOM_ROW) ? '0 : top + 1'b1;
  end

  // Load the output register when a finished result meets a free slot
  assign out_load = out_free &&
                    ((state == ST_DELIVER) ||
                     ((state == ST_IDLE) && accept && !is_read && !scroll));

  // During the sweep the address unit points at the bottom screen row
  assign map_row = (state == ST_SCROLL) ? BOTTOM_ROW : cur_row;
  assign map_col = (state == ST_SCROLL) ? clr_col    : cur_col;

  tccs_addr #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_wr_addr (
    .top  (top),
    .row  (map_row),
    .col  (map_col),
    .addr (map_addr)
  );

  tccs_addr #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_rd_addr (
    .top  (top),
    .row  (rd_row),
    .col  (rd_col),
    .addr (rd_addr)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = map_addr;
    mem_wdata = tccs_pkg::make_cell(ch, fg, bg);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = tccs_pkg::RESET_CELL;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = tccs_pkg::make_cell(tccs_pkg::SPACE_CODE, fg, bg);
      end
      ST_IDLE: begin
        mem_we = accept && !is_read && !is_newline;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tccs_cell_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept && is_read),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  assign out_col_ext = {7'b0, cur_col};
  assign out_row_ext = {5'b0, cur_row};
  assign out_cell    = pend_read_ok ? mem_rdata : '0;

  // Fit the cursor to the fixed result field widths
  function automatic logic [6:0] col_next_out(input logic [CW-1:0] c);
    logic [CW+6:0] e;
    e = {7'b0, c};
    col_next_out = e[6:0];
  endfunction

  function automatic logic [4:0] row_next_out(input logic [RW-1:0] r);
    logic [RW+4:0] e;
    e = {5'b0, r};
    row_next_out = e[4:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      clr_col       <= '0;
      top           <= '0;
      cur_row       <= '0;
      cur_col       <= '0;
      fg            <= tccs_pkg::FG_RESET;
      bg            <= tccs_pkg::BG_RESET;
      pend_read_ok  <= 1'b0;
      pend_scrolled <= 1'b0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tccs_pkg::REG_FOREGROUND: fg <= cfg_data;
          tccs_pkg::REG_BACKGROUND: bg <= cfg_data;
          default: ;
        endcase
      end

      // Hold the result until taken, then drop valid unless a new one loads
      m_tvalid <= out_load || (m_tvalid && !m_tready);

      case (state)
        ST_CLEAR: begin
          // Sweep every cell to a grey-on-black space
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (is_read) begin
              pend_read_ok  <= rd_in_range;
              pend_scrolled <= 1'b0;
              state         <= ST_DELIVER;
            end else begin
              cur_col <= col_next;
              cur_row <= row_next;
              if (scroll) begin
                // Drop the top row through the ring offset, then clear the new bottom row
                top     <= top_next;
                clr_col <= '0;
                state   <= ST_SCROLL;
              end else if (out_free) begin
                m_tdata  <= {3'b000, 1'b0, 16'h0000, row_next_out(row_next),
                             col_next_out(col_next)};
              end else begin
                pend_read_ok  <= 1'b0;
                pend_scrolled <= 1'b0;
                state         <= ST_DELIVER;
              end
            end
          end
        end
        ST_SCROLL: begin
          clr_col <= clr_col + 1'b1;
          if (clr_col == LAST_COL) begin
            pend_read_ok  <= 1'b0;
            pend_scrolled <= 1'b1;
            state         <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (out_free) begin
            m_tdata  <= {3'b000, pend_scrolled, out_cell, out_row_ext[4:0], out_col_ext[6:0]};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A read request always moves to delivery in the cycle after it is accepted
  a_read_to_deliver: assert property (@(posedge clk) disable iff (rst)
    (accept && is_read) |=> (state == ST_DELIVER))
    else $error("read request did not move to delivery");

  // A finished scroll leaves the cursor on the bottom row at column zero
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_SCROLL) |-> (cur_row == BOTTOM_ROW && cur_col == '0))
    else $error("cursor not at bottom row start after scroll");

  // The sweep keeps the write port busy every cycle
  a_sweep_writes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL || state == ST_CLEAR) |-> (mem_we && !s_tready))
    else $error("clear sweep lost the write port");

endmodule

// File: hdl/tccs_cell_mem.sv
module tccs_cell_mem #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tccs_pkg::cell_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tccs_pkg::cell_t rdata
);

  tccs_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/tccs_addr.sv
module tccs_addr #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic [$clog2(ROWS)-1:0]         top,
  input  logic [$clog2(ROWS)-1:0]         row,
  input  logic [$clog2(COLUMNS)-1:0]      col,
  output logic [$clog2(ROWS*COLUMNS)-1:0] addr
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned AW = $clog2(ROWS*COLUMNS);
  localparam int unsigned PW = RW + 10;
  localparam logic [RW:0] ROWS_W = (RW+1)'(ROWS);
  localparam logic [PW-1:0] COLS_P = PW'(COLUMNS);

  logic [RW:0]   sum;
  logic [RW:0]   phys;
  logic [PW-1:0] full;

  // Map a screen row through the ring offset, then to a linear cell address
  always_comb begin
    sum  = {1'b0, top} + {1'b0, row};
    phys = (sum >= ROWS_W) ? sum - ROWS_W : sum;
    full = PW'(phys) * COLS_P + PW'(col);
    addr = full[AW-1:0];
  end

endmodule
